/* rtl/ksi_pkg.sv */
package ksi_pkg;

    localparam int SAMPLE_BITS   = 32;
    localparam int FRACTION_BITS = 16;

    localparam int SB     = SAMPLE_BITS;
    localparam int FB     = FRACTION_BITS;
    localparam int ONE    = 1 << FB;

    // config field widths
    localparam int MODE_W = 2;
    localparam int MU_W   = FB + 1;
    localparam int CFG_W  = FB + 2;
    localparam int IDX_W  = 3;

    // datapath widths
    localparam int CB_W   = FB + 3;
    localparam int A_W    = SB + 3;
    localparam int P_W    = A_W + CB_W;
    localparam int ACC_W  = SB + 6;
    localparam int M_W    = SB + 4;
    localparam int Q_W    = M_W + CB_W;

    localparam int SETTLE_W      = 2;
    localparam int SETTLE_CYCLES = 2;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CUBIC  = 2'd1;

    localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRACTION = 3'd1;
    localparam logic [IDX_W-1:0] REG_TENSION  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BIAS     = 3'd3;

    typedef struct packed {
        logic                    settling;
        logic [MODE_W-1:0]       mode;
        logic signed [CB_W-1:0]  mu;
        logic signed [CB_W-1:0]  mu2;
        logic signed [CB_W-1:0]  mu3;
        logic signed [CB_W-1:0]  kp;
        logic signed [CB_W-1:0]  kn;
        logic signed [CB_W-1:0]  h00;
        logic signed [CB_W-1:0]  h10;
        logic signed [CB_W-1:0]  h01;
        logic signed [CB_W-1:0]  h11;
    } t_coef;

endpackage

/* rtl/keyframe_sample_interpolator.sv */
// Interpolates one Q16.16 coordinate per beat from four neighbouring samples
// (before, from, to, after) at the configured fraction: linear, four-point
// cubic or Hermite with tension and bias; the result saturates to 32 bits.
// The datapath is a five-stage pipeline: one beat in and one beat out per
// cycle while the output is not stalled and no configuration write is
// offered. Mode, fraction, tension and bias feed a small coefficient
// pipeline (mu squared and cubed, Hermite slopes and basis); after reset and
// after every configuration write the input channel stays not ready while
// those registers settle. Configuration writes are always taken and are
// meant to be issued only while no item is in flight.
module keyframe_sample_interpolator
    import ksi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [SB-1:0] i_sample_before,
    input  logic signed [SB-1:0] i_sample_from,
    input  logic signed [SB-1:0] i_sample_to,
    input  logic signed [SB-1:0] i_sample_after,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [SB-1:0] o_interpolated
);

    t_coef coef;

    logic en;
    logic in_beat;
    logic hermite;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: differences and cubic terms
    logic signed [A_W-1:0] y0, y1, y2, y3;
    logic signed [A_W-1:0] n_d10, n_d21, n_d32, n_a0, n_a1, n_a2;
    logic signed [A_W-1:0] r1_d10, r1_d21, r1_d32, r1_a0, r1_a1, r1_a2;
    logic signed [SB-1:0]  r1_y1, r1_y2;

    // stage 2: first products
    logic signed [A_W-1:0]   op_a [4];
    logic signed [CB_W-1:0]  op_b [4];
    logic signed [P_W-1:0]   prod [4];
    logic signed [P_W-1:0]   prod_sh [4];
    logic signed [ACC_W-1:0] r2_p [4];
    logic signed [SB-1:0]    r2_y1, r2_y2;

    // stage 3: sums and slopes
    logic signed [ACC_W-1:0] n_sum, n_m0, n_m1;
    logic signed [ACC_W-1:0] r3_sum;
    logic signed [M_W-1:0]   r3_m0, r3_m1;
    logic signed [SB-1:0]    r3_y1, r3_y2;

    // stage 4: hermite products
    logic signed [M_W-1:0]   qa [4];
    logic signed [CB_W-1:0]  qb [4];
    logic signed [Q_W-1:0]   qprod [4];
    logic signed [Q_W-1:0]   qprod_sh [4];
    logic signed [ACC_W-1:0] r4_q [4];
    logic signed [ACC_W-1:0] r4_sum;

    // stage 5: final sum and saturation
    logic signed [ACC_W-1:0] acc;
    logic signed [SB-1:0]    n_out;
    logic signed [SB-1:0]    r_out;

    ksi_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef)
    );

    assign en          = !r_v5 || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = en && !coef.settling && !i_cfg_valid;
    assign in_beat     = i_in_valid && o_in_ready;
    assign hermite     = (coef.mode != MODE_LINEAR) && (coef.mode != MODE_CUBIC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= in_beat;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_comb begin
        y0    = A_W'(i_sample_before);
        y1    = A_W'(i_sample_from);
        y2    = A_W'(i_sample_to);
        y3    = A_W'(i_sample_after);
        n_d10 = y1 - y0;
        n_d21 = y2 - y1;
        n_d32 = y3 - y2;
        n_a0  = y3 - y2 - y0 + y1;
        n_a1  = y0 - y1 - n_a0;
        n_a2  = y2 - y0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d10 <= n_d10;
            r1_d21 <= n_d21;
            r1_d32 <= n_d32;
            r1_a0  <= n_a0;
            r1_a1  <= n_a1;
            r1_a2  <= n_a2;
            r1_y1  <= i_sample_from;
            r1_y2  <= i_sample_to;
        end
    end

    // operand select per mode
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            op_a[i] = '0;
            op_b[i] = '0;
        end
        case (coef.mode)
            MODE_LINEAR: begin
                op_a[0] = r1_d21; op_b[0] = coef.mu;
            end
            MODE_CUBIC: begin
                op_a[0] = r1_a0;  op_b[0] = coef.mu3;
                op_a[1] = r1_a1;  op_b[1] = coef.mu2;
                op_a[2] = r1_a2;  op_b[2] = coef.mu;
            end
            default: begin
                op_a[0] = r1_d10; op_b[0] = coef.kp;
                op_a[1] = r1_d21; op_b[1] = coef.kn;
                op_a[2] = r1_d21; op_b[2] = coef.kp;
                op_a[3] = r1_d32; op_b[3] = coef.kn;
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            prod[i]    = op_a[i] * op_b[i];
            prod_sh[i] = prod[i] >>> FB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r2_p[i] <= prod_sh[i][ACC_W-1:0];
            end
            r2_y1 <= r1_y1;
            r2_y2 <= r1_y2;
        end
    end

    always_comb begin
        n_sum = ACC_W'(r2_y1) + r2_p[0] + r2_p[1] + r2_p[2] + r2_p[3];
        n_m0  = r2_p[0] + r2_p[1];
        n_m1  = r2_p[2] + r2_p[3];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sum <= n_sum;
            r3_m0  <= n_m0[M_W-1:0];
            r3_m1  <= n_m1[M_W-1:0];
            r3_y1  <= r2_y1;
            r3_y2  <= r2_y2;
        end
    end

    always_comb begin
        qa[0] = M_W'(r3_y1); qb[0] = coef.h00;
        qa[1] = r3_m0;       qb[1] = coef.h10;
        qa[2] = r3_m1;       qb[2] = coef.h01;
        qa[3] = M_W'(r3_y2); qb[3] = coef.h11;
        for (int i = 0; i < 4; i++) begin
            qprod[i]    = qa[i] * qb[i];
            qprod_sh[i] = qprod[i] >>> FB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r4_q[i] <= qprod_sh[i][ACC_W-1:0];
            end
            r4_sum <= r3_sum;
        end
    end

    // saturate to the sample range
    always_comb begin
        acc = hermite ? (r4_q[0] + r4_q[1] + r4_q[2] + r4_q[3]) : r4_sum;
        if ((&acc[ACC_W-1:SB-1]) || !(|acc[ACC_W-1:SB-1])) begin
            n_out = acc[SB-1:0];
        end else if (acc[ACC_W-1]) begin
            n_out = {1'b1, {(SB-1){1'b0}}};
        end else begin
            n_out = {1'b0, {(SB-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_v5;
    assign o_interpolated = r_out;

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !(i_in_valid && o_in_ready))
        else $error("input beat taken right after a configuration write");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input ready while result stalled");

    a_pipe_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && en) |=> o_out_valid)
        else $error("pipeline beat lost before output");

    a_beat_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> r_v1)
        else $error("accepted beat not in first stage");

endmodule

/* rtl/ksi_coef.sv */
module ksi_coef
    import ksi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_coef            o_coef
);

    localparam int KS_W = FB + 3;
    localparam int HW   = FB + 5;
    localparam logic signed [CFG_W-1:0] ONE_S = CFG_W'(ONE);
    localparam logic signed [CFG_W-1:0] NEG_ONE_S = -CFG_W'(ONE);

    logic [MODE_W-1:0]      r_mode;
    logic [MU_W-1:0]        r_frac;
    logic signed [CFG_W-1:0] r_tens;
    logic signed [CFG_W-1:0] r_bias;
    logic [SETTLE_W-1:0]    r_settle;

    logic [MU_W-1:0]        r_mu;
    logic [MU_W-1:0]        r_mu2;
    logic [MU_W-1:0]        r_mu3;
    logic signed [CB_W-1:0] r_kp;
    logic signed [CB_W-1:0] r_kn;
    logic signed [CB_W-1:0] r_h00;
    logic signed [CB_W-1:0] r_h10;
    logic signed [CB_W-1:0] r_h01;
    logic signed [CB_W-1:0] r_h11;

    logic [MU_W-1:0]          mu_c;
    logic signed [CFG_W-1:0]  t_c;
    logic signed [CFG_W-1:0]  b_c;
    logic signed [KS_W-1:0]   opb;
    logic signed [KS_W-1:0]   omb;
    logic signed [KS_W-1:0]   nt;
    logic signed [2*KS_W-1:0] kp_prod;
    logic signed [2*KS_W-1:0] kn_prod;
    logic signed [2*KS_W-1:0] kp_sh;
    logic signed [2*KS_W-1:0] kn_sh;
    logic [2*MU_W-1:0]        mu2_prod;
    logic [2*MU_W-1:0]        mu3_prod;
    logic [2*MU_W-1:0]        mu2_sh;
    logic [2*MU_W-1:0]        mu3_sh;
    logic signed [HW-1:0]     m1s;
    logic signed [HW-1:0]     m2s;
    logic signed [HW-1:0]     m3s;
    logic signed [HW-1:0]     h00_c;
    logic signed [HW-1:0]     h10_c;
    logic signed [HW-1:0]     h01_c;
    logic signed [HW-1:0]     h11_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_LINEAR;
            r_frac   <= '0;
            r_tens   <= '0;
            r_bias   <= '0;
            r_settle <= SETTLE_W'(SETTLE_CYCLES);
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MODE:     r_mode <= i_cfg_data[MODE_W-1:0];
                    REG_FRACTION: r_frac <= i_cfg_data[MU_W-1:0];
                    REG_TENSION:  r_tens <= i_cfg_data;
                    REG_BIAS:     r_bias <= i_cfg_data;
                    default: ;
                endcase
                r_settle <= SETTLE_W'(SETTLE_CYCLES);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 1'b1;
            end
        end
    end

    // clamp config and first products
    always_comb begin
        mu_c = (r_frac > MU_W'(ONE)) ? MU_W'(ONE) : r_frac;
        if (r_tens > ONE_S)           t_c = ONE_S;
        else if (r_tens < NEG_ONE_S)  t_c = NEG_ONE_S;
        else                          t_c = r_tens;
        if (r_bias > ONE_S)           b_c = ONE_S;
        else if (r_bias < NEG_ONE_S)  b_c = NEG_ONE_S;
        else                          b_c = r_bias;
        opb      = KS_W'(ONE) + KS_W'(b_c);
        omb      = KS_W'(ONE) - KS_W'(b_c);
        nt       = KS_W'(ONE) - KS_W'(t_c);
        kp_prod  = opb * nt;
        kn_prod  = omb * nt;
        kp_sh    = kp_prod >>> (FB + 1);
        kn_sh    = kn_prod >>> (FB + 1);
        mu2_prod = mu_c * mu_c;
        mu2_sh   = mu2_prod >> FB;
        mu3_prod = r_mu2 * r_mu;
        mu3_sh   = mu3_prod >> FB;
    end

    // hermite basis
    always_comb begin
        m1s   = HW'(r_mu);
        m2s   = HW'(r_mu2);
        m3s   = HW'(r_mu3);
        h00_c = (m3s <<< 1) - (m2s <<< 1) - m2s + HW'(ONE);
        h10_c = m3s - (m2s <<< 1) + m1s;
        h01_c = m3s - m2s;
        h11_c = (m2s <<< 1) + m2s - (m3s <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_mu  <= mu_c;
        r_mu2 <= mu2_sh[MU_W-1:0];
        r_kp  <= kp_sh[CB_W-1:0];
        r_kn  <= kn_sh[CB_W-1:0];
        r_mu3 <= mu3_sh[MU_W-1:0];
        r_h00 <= h00_c[CB_W-1:0];
        r_h10 <= h10_c[CB_W-1:0];
        r_h01 <= h01_c[CB_W-1:0];
        r_h11 <= h11_c[CB_W-1:0];
    end

    always_comb begin
        o_coef.settling = (r_settle != '0);
        o_coef.mode     = r_mode;
        o_coef.mu       = CB_W'(r_mu);
        o_coef.mu2      = CB_W'(r_mu2);
        o_coef.mu3      = CB_W'(r_mu3);
        o_coef.kp       = r_kp;
        o_coef.kn       = r_kn;
        o_coef.h00      = r_h00;
        o_coef.h10      = r_h10;
        o_coef.h01      = r_h01;
        o_coef.h11      = r_h11;
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import ksi_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 100;
    localparam int DRAIN_CYCLES  = 20;
    localparam int BATCHES       = 12;
    localparam int BATCH_ITEMS   = 52;
    localparam int CALM_BATCHES  = 2;
    localparam int MAX_GAP       = 14;

    localparam logic [MODE_W-1:0] MODE_HERMITE     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HERMITE_ALT = 2'd3;
    localparam logic [IDX_W-1:0]  REG_SPARE        = 3'd4;

    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [CFG_W-1:0] FRAC_TOP = {1'b0, {MU_W{1'b1}}};

    typedef struct packed {
        logic signed [SB-1:0] s_prev;
        logic signed [SB-1:0] s_from;
        logic signed [SB-1:0] s_to;
        logic signed [SB-1:0] s_next;
    } t_keys;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [SB-1:0] i_sample_before = '0;
    logic signed [SB-1:0] i_sample_from = '0;
    logic signed [SB-1:0] i_sample_to = '0;
    logic signed [SB-1:0] i_sample_after = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [SB-1:0] o_interpolated;

    keyframe_sample_interpolator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample_before (i_sample_before),
        .i_sample_from   (i_sample_from),
        .i_sample_to     (i_sample_to),
        .i_sample_after  (i_sample_after),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_interpolated  (o_interpolated)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // shadow of the block's settings
    logic [MODE_W-1:0]       cur_mode = '0;
    logic [MU_W-1:0]         cur_fraction = '0;
    logic signed [CFG_W-1:0] cur_tension = '0;
    logic signed [CFG_W-1:0] cur_bias = '0;

    t_keys                pending_keys[$];
    logic signed [SB-1:0] expected_coords[$];
    t_keys                seen_keys;
    t_keys                next_keys;
    logic signed [SB-1:0] want;

    int  beats_offered = 0;
    int  beats_taken = 0;
    int  send_gap = 0;
    int  stall_gap = 0;
    int  hold_left = 0;
    int  hold_asked = 0;
    int  hold_done = 0;
    int  quiet_cycles = 0;
    int  failures = 0;
    bit  idling_on = 1'b1;
    int  idle_odds = 8;

    function automatic longint scale(input longint v, input longint coef);
        return (v * coef) >>> FB;
    endfunction

    function automatic logic signed [SB-1:0] interpolate(input t_keys k);
        longint y0, y1, y2, y3, mu, mu2, mu3, t, b, nt, kp, kn, m0, m1;
        longint a0, a1, a2, acc, top, bottom;
        y0 = k.s_prev;
        y1 = k.s_from;
        y2 = k.s_to;
        y3 = k.s_next;
        mu = longint'(cur_fraction);
        if (mu > ONE) mu = ONE;
        mu2 = (mu * mu) >>> FB;
        mu3 = (mu2 * mu) >>> FB;
        case (cur_mode)
            MODE_LINEAR: begin
                acc = y1 + scale(y2 - y1, mu);
            end
            MODE_CUBIC: begin
                a0 = y3 - y2 - y0 + y1;
                a1 = y0 - y1 - a0;
                a2 = y2 - y0;
                acc = scale(a0, mu3) + scale(a1, mu2) + scale(a2, mu) + y1;
            end
            default: begin
                t = cur_tension;
                b = cur_bias;
                if (t > ONE) t = ONE;
                if (t < -ONE) t = -ONE;
                if (b > ONE) b = ONE;
                if (b < -ONE) b = -ONE;
                nt = ONE - t;
                kp = ((ONE + b) * nt) >>> (FB + 1);
                kn = ((ONE - b) * nt) >>> (FB + 1);
                m0 = scale(y1 - y0, kp) + scale(y2 - y1, kn);
                m1 = scale(y2 - y1, kp) + scale(y3 - y2, kn);
                acc = scale(y1, 2 * mu3 - 3 * mu2 + ONE)
                    + scale(m0, mu3 - 2 * mu2 + mu)
                    + scale(m1, mu3 - mu2)
                    + scale(y2, 3 * mu2 - 2 * mu3);
            end
        endcase
        top = (longint'(1) <<< (SB - 1)) - 1;
        bottom = -top - 1;
        if (acc > top) acc = top;
        if (acc < bottom) acc = bottom;
        return acc[SB-1:0];
    endfunction

    function automatic logic signed [SB-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return SMIN;
            1: return SMAX;
            2: return '0;
            3: return '1;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_keys make_keys();
        t_keys k;
        logic signed [SB-1:0] base;
        int step;
        case ($urandom_range(0, 3))
            0: begin
                k = {$urandom, $urandom, $urandom, $urandom};
            end
            1: begin
                // smooth track with jitter
                base = $urandom;
                step = $urandom_range(0, 1 << 21) - (1 << 20);
                k.s_prev = base;
                k.s_from = base + step + ($urandom_range(0, 255) - 128);
                k.s_to   = base + 2 * step + ($urandom_range(0, 255) - 128);
                k.s_next = base + 3 * step + ($urandom_range(0, 255) - 128);
            end
            2: begin
                k = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
            end
            default: begin
                k.s_prev = $urandom_range(0, 1 << 22) - (1 << 21);
                k.s_from = $urandom_range(0, 1 << 22) - (1 << 21);
                k.s_to   = $urandom_range(0, 1 << 22) - (1 << 21);
                k.s_next = $urandom_range(0, 1 << 22) - (1 << 21);
            end
        endcase
        return k;
    endfunction

    function automatic logic [CFG_W-1:0] pick_shape();
        case ($urandom_range(0, 5))
            0: return ONE;
            1: return -ONE;
            2: return $urandom;
            default: return $urandom_range(0, 2 * ONE) - ONE;
        endcase
    endfunction

    task automatic put_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] mode_word,
                                  input logic [CFG_W-1:0] frac_word,
                                  input logic [CFG_W-1:0] ten_word,
                                  input logic [CFG_W-1:0] bias_word,
                                  input bit stray);
        put_register(REG_MODE, mode_word);
        put_register(REG_FRACTION, frac_word);
        put_register(REG_TENSION, ten_word);
        put_register(REG_BIAS, bias_word);
        if (stray) put_register(REG_SPARE + IDX_W'($urandom_range(0, 3)), $urandom);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_keys.size() != 0 || beats_offered != beats_taken
               || expected_coords.size() != 0);
    endtask

    task automatic directed_case(input logic [CFG_W-1:0] mode_word,
                                 input logic [CFG_W-1:0] frac_word,
                                 input logic [CFG_W-1:0] ten_word,
                                 input logic [CFG_W-1:0] bias_word,
                                 input bit stray);
        write_settings(mode_word, frac_word, ten_word, bias_word, stray);
        pending_keys.push_back('{SMIN, SMAX, SMIN, SMAX});
        pending_keys.push_back('{SMAX, SMIN, SMAX, SMIN});
        pending_keys.push_back(make_keys());
        drain();
    endtask

    task automatic shuffle_settings();
        logic [CFG_W-1:0] mode_word, frac_word;
        mode_word = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) mode_word[CFG_W-1:MODE_W] = $urandom;
        case ($urandom_range(0, 4))
            0: frac_word = '0;
            1: frac_word = ONE;
            2: frac_word = ONE + $urandom_range(1, ONE - 1);
            default: frac_word = $urandom_range(0, ONE);
        endcase
        // top bit lies outside the fraction field
        if ($urandom_range(0, 7) == 0) frac_word[CFG_W-1] = 1'b1;
        write_settings(mode_word, frac_word, pick_shape(), pick_shape(),
                       $urandom_range(0, 3) == 0);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (beats_offered == beats_taken) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (idling_on && $urandom_range(1, idle_odds) == 1) begin
                send_gap = $urandom_range(1, MAX_GAP) - 1;
                i_in_valid <= 1'b0;
            end else if (pending_keys.size() != 0) begin
                next_keys = pending_keys.pop_front();
                i_sample_before <= next_keys.s_prev;
                i_sample_from   <= next_keys.s_from;
                i_sample_to     <= next_keys.s_to;
                i_sample_after  <= next_keys.s_next;
                i_in_valid <= 1'b1;
                beats_offered = beats_offered + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (stall_gap != 0) begin
            stall_gap = stall_gap - 1;
            i_out_ready <= 1'b0;
        end else if (idling_on && $urandom_range(1, idle_odds) == 1) begin
            stall_gap = $urandom_range(1, MAX_GAP) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // beat monitor, scoreboard and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE:     cur_mode = i_cfg_data[MODE_W-1:0];
                    REG_FRACTION: cur_fraction = i_cfg_data[MU_W-1:0];
                    REG_TENSION:  cur_tension = i_cfg_data;
                    REG_BIAS:     cur_bias = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                seen_keys = '{i_sample_before, i_sample_from, i_sample_to, i_sample_after};
                expected_coords.push_back(interpolate(seen_keys));
                beats_taken = beats_taken + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_coords.size() == 0) begin
                    $error("interpolated: unexpected beat, actual %0d", o_interpolated);
                    failures = failures + 1;
                end else begin
                    want = expected_coords.pop_front();
                    if (o_interpolated !== want) begin
                        $error("interpolated: expected %0d, actual %0d", want, o_interpolated);
                        failures = failures + 1;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_case(MODE_LINEAR, '0, '0, '0, 1'b0);
        directed_case(MODE_LINEAR, ONE, '0, '0, 1'b1);
        directed_case(MODE_LINEAR, FRAC_TOP, '0, '0, 1'b0);
        directed_case(MODE_CUBIC, ONE / 2, '0, '0, 1'b0);
        directed_case(MODE_CUBIC, ONE - 1, ONE, -ONE, 1'b1);
        directed_case(MODE_HERMITE, ONE / 2, -ONE, ONE, 1'b0);
        // tension and bias beyond their bounds
        directed_case(MODE_HERMITE_ALT, ONE / 3, {2'b01, {FB{1'b1}}}, {1'b1, {(CFG_W-1){1'b0}}},
                      1'b1);
        directed_case(MODE_HERMITE, 1, ONE, -ONE, 1'b0);

        for (int batch = 0; batch < BATCHES; batch++) begin
            shuffle_settings();
            idling_on = (batch < BATCHES - CALM_BATCHES);
            idle_odds = $urandom_range(3, 12);
            for (int n = 0; n < BATCH_ITEMS; n++) pending_keys.push_back(make_keys());
            if (batch == 1) hold_asked = hold_asked + 1;
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && expected_coords.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
